// File: design/csv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_pkg
// Shared sizes, register indexes and sequencer states of the circular
// shift volume block.
// ----------------------------------------------------------------------------
package csv_pkg;

   localparam int MAX_SIZE_X   = 64;
   localparam int MAX_SIZE_Y   = 64;
   localparam int MAX_SIZE_Z   = 16;
   localparam int SAMPLE_WIDTH = 32;

   // coordinate widths
   localparam int X_W = $clog2(MAX_SIZE_X);
   localparam int Y_W = $clog2(MAX_SIZE_Y);
   localparam int Z_W = $clog2(MAX_SIZE_Z);

   // register field widths
   localparam int SIZE_X_W = 7;
   localparam int SIZE_Y_W = 7;
   localparam int SIZE_Z_W = 5;
   localparam int OFF_X_W  = 8;
   localparam int OFF_Y_W  = 8;
   localparam int OFF_Z_W  = 6;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   // store geometry
   localparam int STORE_DEPTH = MAX_SIZE_X * MAX_SIZE_Y * MAX_SIZE_Z;
   localparam int ROW_W       = X_W + Y_W;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int VOL_XY_W    = $clog2(MAX_SIZE_X * MAX_SIZE_Y + 1);
   localparam int VOL_W       = $clog2(STORE_DEPTH + 1);

   // request kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_EMIT = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SIZE_X   = 3'd0,
      REG_SIZE_Y   = 3'd1,
      REG_SIZE_Z   = 3'd2,
      REG_OFFSET_X = 3'd3,
      REG_OFFSET_Y = 3'd4,
      REG_OFFSET_Z = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_PREP_MUL1,
      ST_PREP_MUL2,
      ST_PREP_MOD,
      ST_IDLE,
      ST_EMIT_ROW,
      ST_EMIT_ADDR,
      ST_EMIT_READ
   } csv_state_type;

endpackage

// File: design/circular_shift_volume.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_shift_volume
// Circular shift of a 2D or 3D sample volume held in one synchronous store.
// ----------------------------------------------------------------------------
// usage
//   request beat: start with req_kind and req_sample_in, taken when busy is
//   low. kind 0 writes req_sample_in at the load pointer (storage order,
//   z fastest, then y, then x) and gives no result. kind 1 emits the next
//   output position and gives one result beat.
//   result beat: rsp_valid high for one cycle with rsp_sample_out and
//   rsp_last; the receiver cannot stall, so every beat is taken as shown.
//   config: csr_we, csr_index, csr_wdata; write only while no emit is in
//   flight. any write starts a preparation pass (volume product, offsets
//   reduced modulo the axis sizes by repeated add or subtract of the size)
//   that keeps busy high, longest for a large offset against a size of one.
//   emit path: the source row and store address go through two registered
//   multiplies and then the registered store read; the result beat is in the
//   cycle after that read, and a new request may be taken in that same cycle.
//   reset: synchronous, clears the load pointer and output counters, loads
//   the default sizes and offsets, then runs the preparation pass. the
//   store itself is not cleared; entries read before written are garbage.
// ----------------------------------------------------------------------------
module circular_shift_volume
   import csv_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_kind,
   input  logic [SAMPLE_WIDTH-1:0] req_sample_in,
   output logic                    rsp_valid,
   output logic [SAMPLE_WIDTH-1:0] rsp_sample_out,
   output logic                    rsp_last,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   // configuration registers
   logic [SIZE_X_W-1:0] size_x_ff, size_x_in;
   logic [SIZE_Y_W-1:0] size_y_ff, size_y_in;
   logic [SIZE_Z_W-1:0] size_z_ff, size_z_in;
   logic [OFF_X_W-1:0]  offset_x_ff, offset_x_in;
   logic [OFF_Y_W-1:0]  offset_y_ff, offset_y_in;
   logic [OFF_Z_W-1:0]  offset_z_ff, offset_z_in;

   // effective sizes: zero acts as one, too large acts as the maximum
   logic [SIZE_X_W-1:0] eff_x;
   logic [SIZE_Y_W-1:0] eff_y;
   logic [SIZE_Z_W-1:0] eff_z;

   // preparation results
   logic [VOL_XY_W-1:0]        vol_xy_ff, vol_xy_in;
   logic [VOL_W-1:0]           volume_ff, volume_in;
   logic signed [OFF_X_W:0]    modx_ff, modx_in;
   logic signed [OFF_Y_W:0]    mody_ff, mody_in;
   logic signed [OFF_Z_W:0]    modz_ff, modz_in;
   logic signed [OFF_X_W:0]    sx_s;
   logic signed [OFF_Y_W:0]    sy_s;
   logic signed [OFF_Z_W:0]    sz_s;
   logic                       mod_done;

   // sequencer
   csv_state_type state_ff, state_in;
   logic          accept;
   logic          load_go;
   logic          emit_go;

   // counters
   logic [ADDR_W-1:0] load_ptr_ff, load_ptr_in;
   logic [X_W-1:0]    out_x_ff, out_x_in;
   logic [Y_W-1:0]    out_y_ff, out_y_in;
   logic [Z_W-1:0]    out_z_ff, out_z_in;

   // emit path
   logic [X_W-1:0]    nx, src_x;
   logic [Y_W-1:0]    ny, src_y;
   logic [Z_W-1:0]    nz, src_z;
   logic [X_W:0]      sum_x;
   logic [Y_W:0]      sum_y;
   logic [Z_W:0]      sum_z;
   logic              is_last;
   logic [X_W-1:0]    cx_ff, cx_in;
   logic [Y_W-1:0]    cy_ff, cy_in;
   logic [Z_W-1:0]    cz_ff, cz_in;
   logic              last_ff, last_in;
   logic [ROW_W:0]    row_prod;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W:0]   addr_prod;
   logic [ADDR_W-1:0] addr_ff, addr_in;

   // result
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0] rd_data_ff;

   logic [SAMPLE_WIDTH-1:0] store_mem [STORE_DEPTH];

   // ---------------------------------------------------------------- config
   always_comb begin
      size_x_in   = size_x_ff;
      size_y_in   = size_y_ff;
      size_z_in   = size_z_ff;
      offset_x_in = offset_x_ff;
      offset_y_in = offset_y_ff;
      offset_z_in = offset_z_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_SIZE_X:   size_x_in   = csr_wdata[SIZE_X_W-1:0];
            REG_SIZE_Y:   size_y_in   = csr_wdata[SIZE_Y_W-1:0];
            REG_SIZE_Z:   size_z_in   = csr_wdata[SIZE_Z_W-1:0];
            REG_OFFSET_X: offset_x_in = csr_wdata[OFF_X_W-1:0];
            REG_OFFSET_Y: offset_y_in = csr_wdata[OFF_Y_W-1:0];
            REG_OFFSET_Z: offset_z_in = csr_wdata[OFF_Z_W-1:0];
            default: ;  // writes beyond the register list are dropped
         endcase
      end
   end

   always_comb begin
      if (size_x_ff == '0)
         eff_x = SIZE_X_W'(1);
      else if (size_x_ff > SIZE_X_W'(MAX_SIZE_X))
         eff_x = SIZE_X_W'(MAX_SIZE_X);
      else
         eff_x = size_x_ff;
      if (size_y_ff == '0)
         eff_y = SIZE_Y_W'(1);
      else if (size_y_ff > SIZE_Y_W'(MAX_SIZE_Y))
         eff_y = SIZE_Y_W'(MAX_SIZE_Y);
      else
         eff_y = size_y_ff;
      if (size_z_ff == '0)
         eff_z = SIZE_Z_W'(1);
      else if (size_z_ff > SIZE_Z_W'(MAX_SIZE_Z))
         eff_z = SIZE_Z_W'(MAX_SIZE_Z);
      else
         eff_z = size_z_ff;
   end

   // ----------------------------------------------------------- preparation
   // offsets are brought into [0, size) one add or subtract per cycle
   assign sx_s = $signed({{(OFF_X_W + 1 - SIZE_X_W){1'b0}}, eff_x});
   assign sy_s = $signed({{(OFF_Y_W + 1 - SIZE_Y_W){1'b0}}, eff_y});
   assign sz_s = $signed({{(OFF_Z_W + 1 - SIZE_Z_W){1'b0}}, eff_z});

   assign mod_done = (modx_ff >= 0) && (modx_ff < sx_s)
                  && (mody_ff >= 0) && (mody_ff < sy_s)
                  && (modz_ff >= 0) && (modz_ff < sz_s);

   always_comb begin
      vol_xy_in = vol_xy_ff;
      volume_in = volume_ff;
      modx_in   = modx_ff;
      mody_in   = mody_ff;
      modz_in   = modz_ff;
      unique case (state_ff)
         ST_PREP_MUL1: begin
            vol_xy_in = VOL_XY_W'(VOL_XY_W'(eff_x) * VOL_XY_W'(eff_y));
            modx_in   = $signed({offset_x_ff[OFF_X_W-1], offset_x_ff});
            mody_in   = $signed({offset_y_ff[OFF_Y_W-1], offset_y_ff});
            modz_in   = $signed({offset_z_ff[OFF_Z_W-1], offset_z_ff});
         end
         ST_PREP_MUL2: begin
            volume_in = VOL_W'(VOL_W'(vol_xy_ff) * VOL_W'(eff_z));
         end
         ST_PREP_MOD: begin
            if (modx_ff < 0)
               modx_in = modx_ff + sx_s;
            else if (modx_ff >= sx_s)
               modx_in = modx_ff - sx_s;
            if (mody_ff < 0)
               mody_in = mody_ff + sy_s;
            else if (mody_ff >= sy_s)
               mody_in = mody_ff - sy_s;
            if (modz_ff < 0)
               modz_in = modz_ff + sz_s;
            else if (modz_ff >= sz_s)
               modz_in = modz_ff - sz_s;
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------- sequencer
   assign accept  = start && (state_ff == ST_IDLE);
   assign load_go = accept && (req_kind == KIND_LOAD);
   assign emit_go = accept && (req_kind == KIND_EMIT);

   always_comb begin
      state_in = state_ff;
      priority if (csr_we) begin
         state_in = ST_PREP_MUL1;
      end else begin
         unique case (state_ff)
            ST_PREP_MUL1: state_in = ST_PREP_MUL2;
            ST_PREP_MUL2: state_in = ST_PREP_MOD;
            ST_PREP_MOD:  state_in = mod_done ? ST_IDLE : ST_PREP_MOD;
            ST_IDLE:      state_in = emit_go ? ST_EMIT_ROW : ST_IDLE;
            ST_EMIT_ROW:  state_in = ST_EMIT_ADDR;
            ST_EMIT_ADDR: state_in = ST_EMIT_READ;
            ST_EMIT_READ: state_in = ST_IDLE;
            default:      state_in = ST_PREP_MUL1;
         endcase
      end
   end

   always_comb begin
      busy         = (state_ff != ST_IDLE);
      rsp_valid_in = (state_ff == ST_EMIT_READ);
   end

   // ------------------------------------------------------------- load side
   always_comb begin
      load_ptr_in = load_ptr_ff;
      if (load_go) begin
         if ((VOL_W'(load_ptr_ff) + VOL_W'(1)) >= volume_ff)
            load_ptr_in = '0;
         else
            load_ptr_in = load_ptr_ff + ADDR_W'(1);
      end
   end

   // ------------------------------------------------------------- emit side
   always_comb begin
      // counters left beyond a shrunk axis restart at zero
      nx = ({1'b0, out_x_ff} >= eff_x) ? '0 : out_x_ff;
      ny = ({1'b0, out_y_ff} >= eff_y) ? '0 : out_y_ff;
      nz = ({1'b0, out_z_ff} >= eff_z) ? '0 : out_z_ff;

      // both terms below the size, so one subtract wraps
      sum_x = {1'b0, nx} + {1'b0, modx_ff[X_W-1:0]};
      sum_y = {1'b0, ny} + {1'b0, mody_ff[Y_W-1:0]};
      sum_z = {1'b0, nz} + {1'b0, modz_ff[Z_W-1:0]};
      src_x = (sum_x >= (X_W+1)'(eff_x)) ? X_W'(sum_x - (X_W+1)'(eff_x)) : X_W'(sum_x);
      src_y = (sum_y >= (Y_W+1)'(eff_y)) ? Y_W'(sum_y - (Y_W+1)'(eff_y)) : Y_W'(sum_y);
      src_z = (sum_z >= (Z_W+1)'(eff_z)) ? Z_W'(sum_z - (Z_W+1)'(eff_z)) : Z_W'(sum_z);

      is_last = ({1'b0, nx} == eff_x - SIZE_X_W'(1))
             && ({1'b0, ny} == eff_y - SIZE_Y_W'(1))
             && ({1'b0, nz} == eff_z - SIZE_Z_W'(1));

      out_x_in = out_x_ff;
      out_y_in = out_y_ff;
      out_z_in = out_z_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cz_in    = cz_ff;
      last_in  = last_ff;
      if (emit_go) begin
         cx_in   = src_x;
         cy_in   = src_y;
         cz_in   = src_z;
         last_in = is_last;
         priority if (is_last) begin
            out_x_in = '0;
            out_y_in = '0;
            out_z_in = '0;
         end else if (({1'b0, nz} + (Z_W+1)'(1)) < (Z_W+1)'(eff_z)) begin
            out_x_in = nx;
            out_y_in = ny;
            out_z_in = nz + Z_W'(1);
         end else if (({1'b0, ny} + (Y_W+1)'(1)) < (Y_W+1)'(eff_y)) begin
            out_x_in = nx;
            out_y_in = ny + Y_W'(1);
            out_z_in = '0;
         end else begin
            out_x_in = nx + X_W'(1);
            out_y_in = '0;
            out_z_in = '0;
         end
      end

      // address = z + size_z * (y + size_y * x), one multiply per stage
      row_prod  = (ROW_W+1)'((ROW_W+1)'(cx_ff) * (ROW_W+1)'(eff_y)) + (ROW_W+1)'(cy_ff);
      row_in    = ROW_W'(row_prod);
      addr_prod = (ADDR_W+1)'((ADDR_W+1)'(row_ff) * (ADDR_W+1)'(eff_z))
                + (ADDR_W+1)'(cz_ff);
      addr_in   = ADDR_W'(addr_prod);
   end

   // ------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_PREP_MUL1;
         size_x_ff    <= SIZE_X_W'(MAX_SIZE_X);
         size_y_ff    <= SIZE_Y_W'(MAX_SIZE_Y);
         size_z_ff    <= SIZE_Z_W'(1);
         offset_x_ff  <= '0;
         offset_y_ff  <= '0;
         offset_z_ff  <= '0;
         load_ptr_ff  <= '0;
         out_x_ff     <= '0;
         out_y_ff     <= '0;
         out_z_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_x_ff    <= size_x_in;
         size_y_ff    <= size_y_in;
         size_z_ff    <= size_z_in;
         offset_x_ff  <= offset_x_in;
         offset_y_ff  <= offset_y_in;
         offset_z_ff  <= offset_z_in;
         load_ptr_ff  <= load_ptr_in;
         out_x_ff     <= out_x_in;
         out_y_ff     <= out_y_in;
         out_z_ff     <= out_z_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      vol_xy_ff <= vol_xy_in;
      volume_ff <= volume_in;
      modx_ff   <= modx_in;
      mody_ff   <= mody_in;
      modz_ff   <= modz_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      cz_ff     <= cz_in;
      last_ff   <= last_in;
      row_ff    <= row_in;
      addr_ff   <= addr_in;
   end

   // sample store: one write per load, one registered read per emit
   always_ff @(posedge clock) begin
      if (load_go)
         store_mem[load_ptr_ff] <= req_sample_in;
      if (state_ff == ST_EMIT_READ)
         rd_data_ff <= store_mem[addr_ff];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rd_data_ff;
   assign rsp_last       = last_ff;

   // ------------------------------------------------------------ assertions
   a_beat_follows_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_EMIT_READ))
      else $error("result beat without a store read");

   a_cfg_write_blocks: assert property (@(posedge clock) disable iff (reset)
      $past(csr_we) |-> busy)
      else $error("request window open right after a register write");

   a_offsets_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> mod_done)
      else $error("idle with offsets not reduced");

   a_last_rewinds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (out_x_ff == '0 && out_y_ff == '0 && out_z_ff == '0))
      else $error("output counters not rewound after final beat");

endmodule
